// File: src/assert_macros.svh
// Assertion macros used by the RTL of the execute core.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// File: src/rv32x_pkg.sv
// Types and constants of the execute core: opcodes, function codes, state codes.
// No dependencies.
package rv32x_pkg;
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] F7_BASE   = 7'b0000000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_READ  = 8'b00000100,
        ST_EXEC  = 8'b00001000,
        ST_DIV   = 8'b00010000,
        ST_MEM   = 8'b00100000,
        ST_WB    = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;
endpackage

// File: src/rv32x_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module rv32x_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/rv32_subset_execute_core.sv
// Execute core of an RV32IM subset; depends on rv32x_pkg, rv32x_ram and assert_macros.svh.
// The result beat is offered after the READ, EXEC and WB states; LW adds MEM, and
// DIV and REM with a nonzero divisor and no overflow add DIV (one quotient bit a cycle).
// One instruction at a time; the next beat is taken at the earliest in the cycle after
// the result beat is accepted.
// Reset zeroes the PC, then state CLEAR zeroes both register file RAMs and the data RAM.
`include "assert_macros.svh"
module rv32_subset_execute_core #(
    parameter int DATA_WORDS = 2048
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // instruction
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc, reg_write, dest_reg, write_value, store_done, store_index,
    // store_value, branch_taken, unsupported, zero fill
    output logic [((105 + $clog2(DATA_WORDS) + 7) / 8) * 8 - 1:0] m_tdata
);
    import rv32x_pkg::*;

    localparam int AW = $clog2(DATA_WORDS);
    localparam int OW = ((105 + AW + 7) / 8) * 8;
    localparam int CLR_N = (DATA_WORDS > 32) ? DATA_WORDS : 32;
    localparam int CW = $clog2(CLR_N);

    state_t state_reg, state_next;
    logic [CW-1:0] clr_reg;
    logic [31:0] pc_reg, ins_reg, a_reg, b_reg, val_reg, npc_reg;
    logic        wr_reg, st_reg, taken_reg, bad_reg;
    logic [AW-1:0] sidx_reg;
    logic [31:0] sval_reg;
    logic [4:0]  rd_reg;

    // Divider.
    logic [31:0] dq_reg, dr_reg, dd_reg;
    logic [5:0]  dcnt_reg;

    logic [31:0] rf_a, rf_b, dm_q;
    logic        rf_we, dm_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata, dm_wdata;
    logic [AW-1:0] dm_waddr, dm_raddr;

    logic [6:0] op, f7;
    logic [2:0] f3;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, ls_addr;
    logic        lt_s, lt_u;

    assign op = ins_reg[6:0];
    assign f3 = ins_reg[14:12];
    assign f7 = ins_reg[31:25];
    assign imm_i = {{20{ins_reg[31]}}, ins_reg[31:20]};
    assign imm_s = {{20{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
    assign imm_b = {{19{ins_reg[31]}}, ins_reg[31], ins_reg[7], ins_reg[30:25],
                    ins_reg[11:8], 1'b0};
    assign imm_j = {{11{ins_reg[31]}}, ins_reg[31], ins_reg[19:12], ins_reg[20],
                    ins_reg[30:21], 1'b0};
    assign ls_addr = a_reg + ((op == OP_STORE) ? imm_s : imm_i);
    assign lt_s = ($signed(a_reg) < $signed(b_reg));
    assign lt_u = (a_reg < b_reg);

    logic [4:0] ra1, ra2;
    assign ra1 = (state_reg == ST_IDLE) ? s_tdata[19:15] : ins_reg[19:15];
    assign ra2 = (state_reg == ST_IDLE) ? s_tdata[24:20] : ins_reg[24:20];

    assign dm_raddr = ls_addr[AW+1:2];

    rv32x_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .aclk(aclk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(ra1), .rdata(rf_a));
    rv32x_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .aclk(aclk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(ra2), .rdata(rf_b));
    rv32x_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
        .aclk(aclk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
        .raddr(dm_raddr), .rdata(dm_q));

    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = rd_reg;
        rf_wdata = val_reg;
        dm_we    = 1'b0;
        dm_waddr = sidx_reg;
        dm_wdata = sval_reg;
        if (state_reg == ST_CLEAR) begin
            rf_we    = 1'b1;
            rf_waddr = clr_reg[4:0];
            rf_wdata = '0;
            dm_we    = 1'b1;
            dm_waddr = clr_reg[AW-1:0];
            dm_wdata = '0;
        end else if (state_reg == ST_WB) begin
            rf_we = wr_reg && (rd_reg != 5'd0);
            dm_we = st_reg;
        end
    end

    // Divider operands: magnitudes, shift-subtract one bit per cycle.
    logic [31:0] mag_a, mag_b;
    logic [32:0] dtrial;
    logic [31:0] dshift;
    assign mag_a = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign mag_b = b_reg[31] ? (32'd0 - b_reg) : b_reg;
    assign dshift = {dr_reg[30:0], dq_reg[31]};
    assign dtrial = {1'b0, dshift} - {1'b0, dd_reg};

    logic [31:0] q_s, r_s;
    assign q_s = (a_reg[31] ^ b_reg[31]) ? (32'd0 - dq_reg) : dq_reg;
    assign r_s = a_reg[31] ? (32'd0 - dr_reg) : dr_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == CW'(CLR_N - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC: begin
                if (op == OP_REG && f7 == F7_MULDIV && (f3 == F3_XOR || f3 == F3_OR)
                    && b_reg != 32'd0
                    && !(a_reg == 32'h8000_0000 && b_reg == 32'hFFFF_FFFF)) begin
                    state_next = ST_DIV;
                end else if (op == OP_LOAD && f3 == F3_WORD) begin
                    state_next = ST_MEM;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_DIV:   if (dcnt_reg == 6'd32) state_next = ST_WB;
            ST_MEM:   state_next = ST_WB;
            ST_WB:    state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + CW'(1);
            if (state_reg == ST_WB) pc_reg <= npc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: ins_reg <= s_tdata;
            ST_READ: begin
                a_reg <= rf_a;
                b_reg <= rf_b;
            end
            ST_EXEC: begin
                wr_reg    <= 1'b0;
                st_reg    <= 1'b0;
                taken_reg <= 1'b0;
                bad_reg   <= 1'b0;
                val_reg   <= '0;
                sidx_reg  <= ls_addr[AW+1:2];
                sval_reg  <= b_reg;
                rd_reg    <= ins_reg[11:7];
                npc_reg   <= pc_reg + 32'd4;
                dq_reg    <= mag_a;
                dr_reg    <= '0;
                dd_reg    <= mag_b;
                dcnt_reg  <= '0;
                if (op == OP_REG) begin
                    wr_reg <= 1'b1;
                    if (f3 == F3_ADD && f7 == F7_BASE) val_reg <= a_reg + b_reg;
                    else if (f3 == F3_ADD && f7 == F7_ALT) val_reg <= a_reg - b_reg;
                    else if (f3 == F3_ADD && f7 == F7_MULDIV) val_reg <= a_reg * b_reg;
                    else if (f3 == F3_AND && f7 == F7_BASE) val_reg <= a_reg & b_reg;
                    else if (f3 == F3_OR && f7 == F7_BASE) val_reg <= a_reg | b_reg;
                    else if (f3 == F3_XOR && f7 == F7_BASE) val_reg <= a_reg ^ b_reg;
                    else if (f3 == F3_SLT && f7 == F7_BASE) val_reg <= {31'd0, lt_s};
                    else if (f3 == F3_OR && f7 == F7_MULDIV) begin
                        val_reg <= (b_reg == 32'd0) ? a_reg : 32'd0;
                    end else if (f3 == F3_XOR && f7 == F7_MULDIV) begin
                        val_reg <= (b_reg == 32'd0) ? 32'hFFFF_FFFF : 32'h8000_0000;
                    end else begin
                        wr_reg  <= 1'b0;
                        bad_reg <= 1'b1;
                    end
                end else if (op == OP_IMM) begin
                    wr_reg  <= 1'b1;
                    val_reg <= a_reg + imm_i;
                end else if (op == OP_LOAD) begin
                    if (f3 == F3_WORD) wr_reg <= 1'b1;
                    else bad_reg <= 1'b1;
                end else if (op == OP_STORE) begin
                    if (f3 == F3_WORD) st_reg <= 1'b1;
                    else bad_reg <= 1'b1;
                end else if (op == OP_BRANCH) begin
                    logic tk;
                    tk = 1'b0;
                    case (f3)
                        F3_BEQ:  tk = (a_reg == b_reg);
                        F3_BNE:  tk = (a_reg != b_reg);
                        F3_BLT:  tk = lt_s;
                        F3_BGE:  tk = !lt_s;
                        F3_BLTU: tk = lt_u;
                        F3_BGEU: tk = !lt_u;
                        default: bad_reg <= 1'b1;
                    endcase
                    taken_reg <= tk;
                    if (tk) npc_reg <= pc_reg + imm_b;
                end else if (op == OP_JAL) begin
                    wr_reg    <= 1'b1;
                    val_reg   <= pc_reg + 32'd4;
                    taken_reg <= 1'b1;
                    npc_reg   <= pc_reg + imm_j;
                end else begin
                    bad_reg <= 1'b1;
                end
            end
            ST_DIV: begin
                if (dcnt_reg == 6'd32) begin
                    val_reg <= (f3 == F3_XOR) ? q_s : r_s;
                end else begin
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (!dtrial[32]) begin
                        dr_reg <= dtrial[31:0];
                        dq_reg <= {dq_reg[30:0], 1'b1};
                    end else begin
                        dr_reg <= dshift;
                        dq_reg <= {dq_reg[30:0], 1'b0};
                    end
                end
            end
            ST_MEM: val_reg <= dm_q;
            ST_WB: begin
                if (!wr_reg || rd_reg == 5'd0) begin
                    wr_reg  <= 1'b0;
                    rd_reg  <= '0;
                    val_reg <= '0;
                end
                if (!st_reg) begin
                    sidx_reg <= '0;
                    sval_reg <= '0;
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = OW'({bad_reg, taken_reg, sval_reg, sidx_reg, st_reg, val_reg,
                          rd_reg, wr_reg, npc_reg});

    `ASSERT_CLK(a_no_x0_write, aclk, aresetn,
        !(m_tvalid && wr_reg && rd_reg == 5'd0), "write to x0 reported")
    `ASSERT_CLK(a_rdy_out_excl, aclk, aresetn,
        !(s_tready && m_tvalid), "input and output both open")
    `ASSERT_NEXT(a_pc_update, aclk, aresetn, state_reg == ST_WB,
        pc_reg == $past(npc_reg), "program counter not updated")
endmodule
